// ===== sv/lisr_pkg.sv =====
// shared constants, codes and types for the linear interpolating sample reader
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps

package lisr_pkg;

  localparam int TABLE_DEPTH   = 4096;
  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 16;
  localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
  localparam int IDX_BITS      = 12;
  localparam int TIME_BITS     = 32;
  localparam int RATE_BITS     = 18;
  localparam int LEN_BITS      = 13;
  localparam int POS_BITS      = TIME_BITS + RATE_BITS;
  localparam int INT_BITS      = POS_BITS - FRAC_BITS;
  localparam int KIND_BITS     = 2;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 18;
  localparam int DIFF_BITS     = SAMPLE_BITS + 1;
  localparam int MPROD_BITS    = DIFF_BITS + FRAC_BITS + 1;
  localparam int SHIFT_BITS    = MPROD_BITS - FRAC_BITS;

  localparam logic [KIND_BITS-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_NEAREST = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_LINEAR  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_RATE  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TABLE_LENGTH = 1'd1;

  localparam logic [RATE_BITS-1:0] RATE_RESET = 18'd48000;
  localparam logic [LEN_BITS-1:0]  LEN_RESET  = LEN_BITS'(TABLE_DEPTH);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // load enables for the interpolation stages
  typedef struct packed {
    logic s4;
    logic s5;
  } lisr_stage_en_t;

endpackage

// ===== sv/lisr_if.sv =====
// valid/ready channel interfaces: sample input, result output, register write
// depends on lisr_pkg for payload widths
`timescale 1ns / 1ps

interface lisr_in_if;
  logic                               valid;
  logic                               ready;
  logic [lisr_pkg::KIND_BITS-1:0]     kind;
  logic [lisr_pkg::IDX_BITS-1:0]      sample_index;
  logic signed [lisr_pkg::SAMPLE_BITS-1:0] sample_value;
  logic [lisr_pkg::TIME_BITS-1:0]     read_time;

  modport source (output valid, kind, sample_index, sample_value, read_time, input ready);
  modport sink (input valid, kind, sample_index, sample_value, read_time, output ready);
endinterface

interface lisr_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [lisr_pkg::SAMPLE_BITS-1:0] value;
  logic                                    out_of_range;

  modport source (output valid, value, out_of_range, input ready);
  modport sink (input valid, value, out_of_range, output ready);
endinterface

interface lisr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lisr_pkg::CFG_IDX_BITS-1:0]  index;
  logic [lisr_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/lisr_interp.sv =====
// slope, slope times fraction, and final select of the read result
// depends on lisr_pkg; load enables come from the top level stall chain
`timescale 1ns / 1ps

module lisr_interp (
  input  logic                              clk,
  input  lisr_pkg::lisr_stage_en_t          en,
  input  lisr_pkg::sample_t                 s3_d0,
  input  lisr_pkg::sample_t                 s3_d1,
  input  logic [lisr_pkg::FRAC_BITS-1:0]    s3_frac,
  input  logic [lisr_pkg::KIND_BITS-1:0]    s3_kind,
  input  logic                              s3_oor,
  output lisr_pkg::sample_t                 value,
  output logic                              out_of_range
);

  logic signed [lisr_pkg::DIFF_BITS-1:0]  s4_diff;
  lisr_pkg::sample_t                      s4_d0;
  logic [lisr_pkg::FRAC_BITS-1:0]         s4_frac;
  logic [lisr_pkg::KIND_BITS-1:0]         s4_kind;
  logic                                   s4_oor;

  logic signed [lisr_pkg::MPROD_BITS-1:0] s5_mprod;
  lisr_pkg::sample_t                      s5_d0;
  logic [lisr_pkg::KIND_BITS-1:0]         s5_kind;
  logic                                   s5_oor;

  logic signed [lisr_pkg::SHIFT_BITS-1:0] shifted;
  logic signed [lisr_pkg::SHIFT_BITS-1:0] lin_sum;

  always_ff @(posedge clk) begin
    if (en.s4) begin
      s4_diff <= lisr_pkg::DIFF_BITS'(s3_d1) - lisr_pkg::DIFF_BITS'(s3_d0);
      s4_d0   <= s3_d0;
      s4_frac <= s3_frac;
      s4_kind <= s3_kind;
      s4_oor  <= s3_oor;
    end
    if (en.s5) begin
      // fraction is unsigned, so it goes in with a zero sign bit
      s5_mprod <= lisr_pkg::MPROD_BITS'(s4_diff) *
                  lisr_pkg::MPROD_BITS'($signed({1'b0, s4_frac}));
      s5_d0    <= s4_d0;
      s5_kind  <= s4_kind;
      s5_oor   <= s4_oor;
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign shifted = lisr_pkg::SHIFT_BITS'(s5_mprod >>> lisr_pkg::FRAC_BITS);
  assign lin_sum = lisr_pkg::SHIFT_BITS'(s5_d0) + shifted;

  always_comb begin
    value = '0;
    case (s5_kind)
      lisr_pkg::KIND_NEAREST: value = s5_oor ? '0 : s5_d0;
      lisr_pkg::KIND_LINEAR:  value = s5_oor ? '0 : lin_sum[lisr_pkg::SAMPLE_BITS-1:0];
      default:                value = '0;
    endcase
  end

  assign out_of_range = s5_oor;

endmodule

// ===== sv/linear_interp_sample_reader_top.sv =====
// throughput: one word per cycle while the output accepts results;
// the sample table has one write and two read ports
// the product time * rate is registered, then range check and table access, then
// slope, slope * fraction, and sum; stalls back up stage by stage into bubbles
// reset clears all valid bits and sets sample_rate 48000, table_length 4096;
// table contents stay undefined until written
`timescale 1ns / 1ps

module linear_interp_sample_reader_top (
  input  logic              clk,
  input  logic              rst,
  lisr_in_if.sink           smp_in,
  lisr_out_if.source        smp_out,
  lisr_cfg_if.sink          cfg
);

  logic [lisr_pkg::RATE_BITS-1:0] sample_rate;
  logic [lisr_pkg::LEN_BITS-1:0]  eff_len;
  logic [lisr_pkg::LEN_BITS-1:0]  len_clamped;

  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, o_valid;
  logic s1_go, s2_go, s3_go, s4_go, s5_go, out_go;

  logic [lisr_pkg::KIND_BITS-1:0] s1_kind, s2_kind, s3_kind;
  logic [lisr_pkg::IDX_BITS-1:0]  s1_idx, s2_idx;
  lisr_pkg::sample_t              s1_value, s2_value;
  logic [lisr_pkg::TIME_BITS-1:0] s1_time;
  logic [lisr_pkg::POS_BITS-1:0]  s2_pos;

  lisr_pkg::sample_t              s3_d0, s3_d1;
  logic [lisr_pkg::FRAC_BITS-1:0] s3_frac;
  logic                           s3_oor;

  logic [lisr_pkg::INT_BITS-1:0]  pos_int;
  logic [lisr_pkg::LEN_BITS-1:0]  pos_next;
  logic                           rd_oor, wr_oor, oor_next;
  logic [lisr_pkg::ADDR_BITS-1:0] rd_addr0, rd_addr1, wr_addr;
  logic                           wr_en;

  lisr_pkg::sample_t              mem [lisr_pkg::TABLE_DEPTH];

  lisr_pkg::lisr_stage_en_t       stage_en;
  lisr_pkg::sample_t              s5_result;
  logic                           s5_oor;

  // configuration
  assign cfg.ready = 1'b1;
  assign len_clamped = (cfg.data[lisr_pkg::LEN_BITS-1:0] > lisr_pkg::LEN_RESET)
                     ? lisr_pkg::LEN_RESET : cfg.data[lisr_pkg::LEN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= lisr_pkg::RATE_RESET;
      eff_len     <= lisr_pkg::LEN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lisr_pkg::CFG_SAMPLE_RATE:  sample_rate <= cfg.data[lisr_pkg::RATE_BITS-1:0];
        lisr_pkg::CFG_TABLE_LENGTH: eff_len     <= len_clamped;
        default: ;
      endcase
    end
  end

  // stall chain: a stage loads when empty or when its word moves on
  assign out_go = !o_valid || smp_out.ready;
  assign s5_go  = !s5_valid || out_go;
  assign s4_go  = !s4_valid || s5_go;
  assign s3_go  = !s3_valid || s4_go;
  assign s2_go  = !s2_valid || s3_go;
  assign s1_go  = !s1_valid || s2_go;
  assign smp_in.ready = s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (s1_go)  s1_valid <= smp_in.valid;
      if (s2_go)  s2_valid <= s1_valid;
      if (s3_go)  s3_valid <= s2_valid;
      if (s4_go)  s4_valid <= s3_valid;
      if (s5_go)  s5_valid <= s4_valid;
      if (out_go) o_valid  <= s5_valid;
    end
  end

  // stage 1 and 2: input capture, then time * rate
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1_kind  <= smp_in.kind;
      s1_idx   <= smp_in.sample_index;
      s1_value <= smp_in.sample_value;
      s1_time  <= smp_in.read_time;
    end
    if (s2_go) begin
      s2_kind  <= s1_kind;
      s2_idx   <= s1_idx;
      s2_value <= s1_value;
      s2_pos   <= lisr_pkg::POS_BITS'(s1_time) * lisr_pkg::POS_BITS'(sample_rate);
    end
  end

  // range checks and table addresses
  assign pos_int  = s2_pos[lisr_pkg::POS_BITS-1:lisr_pkg::FRAC_BITS];
  assign rd_oor   = pos_int >= lisr_pkg::INT_BITS'(eff_len);
  assign wr_oor   = lisr_pkg::LEN_BITS'(s2_idx) >= eff_len;
  assign pos_next = pos_int[lisr_pkg::LEN_BITS-1:0] + lisr_pkg::LEN_BITS'(1);
  assign rd_addr0 = pos_int[lisr_pkg::ADDR_BITS-1:0];
  // the entry after the last one wraps to entry 0
  assign rd_addr1 = (pos_next == eff_len) ? '0 : pos_next[lisr_pkg::ADDR_BITS-1:0];
  assign wr_addr  = s2_idx[lisr_pkg::ADDR_BITS-1:0];

  always_comb begin
    oor_next = 1'b0;
    case (s2_kind) inside
      lisr_pkg::KIND_WRITE:   oor_next = wr_oor;
      lisr_pkg::KIND_NEAREST,
      lisr_pkg::KIND_LINEAR:  oor_next = rd_oor;
      default:                oor_next = 1'b0;
    endcase
  end

  // writes and reads both happen as a word leaves stage 2, so table order matches word order
  assign wr_en = s3_go && s2_valid && (s2_kind == lisr_pkg::KIND_WRITE) && !wr_oor;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= s2_value;
    if (s3_go) begin
      s3_d0   <= mem[rd_addr0];
      s3_d1   <= mem[rd_addr1];
      s3_frac <= s2_pos[lisr_pkg::FRAC_BITS-1:0];
      s3_kind <= s2_kind;
      s3_oor  <= oor_next;
    end
  end

  assign stage_en.s4 = s4_go;
  assign stage_en.s5 = s5_go;

  lisr_interp u_interp (
    .clk          (clk),
    .en           (stage_en),
    .s3_d0        (s3_d0),
    .s3_d1        (s3_d1),
    .s3_frac      (s3_frac),
    .s3_kind      (s3_kind),
    .s3_oor       (s3_oor),
    .value        (s5_result),
    .out_of_range (s5_oor)
  );

  // output register
  always_ff @(posedge clk) begin
    if (out_go) begin
      smp_out.value        <= s5_result;
      smp_out.out_of_range <= s5_oor;
    end
  end

  assign smp_out.valid = o_valid;

endmodule

// ===== sv/lisr_checker.sv =====
// port-level checks for the sample reader: word accounting and result consistency
// depends on lisr_pkg; attached to the top level by the bind at the end
`timescale 1ns / 1ps

module lisr_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input lisr_pkg::sample_t       out_value,
  input logic                    out_oor
);

  logic [2:0] pending;
  logic [2:0] pending_next;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pending_next = pending;
    if (in_acc && !out_acc) pending_next = pending + 3'd1;
    if (out_acc && !in_acc) pending_next = pending - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  // no result word without an accepted word behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result word with no word in flight");

  // six stages hold at most six words
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd6)
    else $error("more words in flight than stages");

  // an out of range result always reads as zero
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_oor) |-> out_value == '0)
    else $error("out of range result with nonzero value");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_value) && $stable(out_oor))
    else $error("stalled result word changed");

endmodule

bind linear_interp_sample_reader_top lisr_checker u_lisr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (smp_in.valid),
  .in_ready  (smp_in.ready),
  .out_valid (smp_out.valid),
  .out_ready (smp_out.ready),
  .out_value (smp_out.value),
  .out_oor   (smp_out.out_of_range)
);
